[rtl/core/rcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the RGB 3x3 convolution unit
// Kernel and window types, register indexes and reset values.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COEF_FRAC_DEF  = 12;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int CFG_W      = 48;
  localparam int LWIDTH_W   = 11;
  localparam int TAPS       = 9;
  localparam int SUM_W      = 28;
  localparam int RGB_W      = 3 * PIX_W;

  localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = 11'd1024;
  localparam logic [CFG_W-1:0]    COEF_TOP_RST   = 48'h0000_F800_0000;
  localparam logic [CFG_W-1:0]    COEF_MID_RST   = 48'hF800_3000_F800;
  localparam logic [CFG_W-1:0]    COEF_BOT_RST   = 48'h0000_F800_0000;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_COEF_TOP   = 2'd1,
    REG_COEF_MID   = 2'd2,
    REG_COEF_BOT   = 2'd3
  } cfg_reg_t;

  // Tap order: row-major, top row first, left column first
  typedef logic [TAPS-1:0][COEF_W-1:0] kernel_t;
  typedef logic [TAPS-1:0][PIX_W-1:0]  taps_t;

endpackage

[rtl/core/rcc_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_channel: one color channel of the 3x3 convolution
// Nine signed products, sum, floor shift and clamp to the 8-bit range.
// ----------------------------------------------------------------------------
module rcc_channel #(
  parameter int COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_DEF
) (
  input  rcc_pkg::taps_t             taps,
  input  rcc_pkg::kernel_t           kernel,
  output logic [rcc_pkg::PIX_W-1:0]  result
);

  localparam int PROD_W = rcc_pkg::PIX_W + 1 + rcc_pkg::COEF_W;
  localparam int QW     = rcc_pkg::SUM_W - COEF_FRAC_BITS;

  logic signed [PROD_W-1:0]        prod [rcc_pkg::TAPS];
  logic signed [rcc_pkg::SUM_W-1:0] acc;
  logic        [QW-1:0]            quot;

  always_comb begin
    for (int i = 0; i < rcc_pkg::TAPS; i++) begin
      prod[i] = $signed({1'b0, taps[i]}) * $signed(kernel[i]);
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < rcc_pkg::TAPS; i++) begin
      acc = acc + rcc_pkg::SUM_W'(prod[i]);
    end
  end

  assign quot = acc[rcc_pkg::SUM_W-1:COEF_FRAC_BITS];

  always_comb begin
    if (acc[rcc_pkg::SUM_W-1]) begin
      result = '0;
    end else if (|quot[QW-1:rcc_pkg::PIX_W]) begin
      result = '1;
    end else begin
      result = quot[rcc_pkg::PIX_W-1:0];
    end
  end

endmodule

[rtl/core/rgb_conv3x3_clamp_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp_unit: streaming 3x3 convolution of RGB pixels
// Pixels enter in raster order on the in_ channel. Two line stores (one
// combined memory) and a 3x2 window feed a programmable 3x3 kernel per
// channel; sums are shifted right (floor) and clamped to 0..255.
// Only interior pixels give a result, centred one row and one column back;
// out_row_last marks the last result of a row. in_frame_start restarts the
// row and column counters.
// A pixel's transaction edge reads the line store into the read stage; the
// output register loads the filter result when the read stage advances.
// Throughput: one pixel per cycle while the receiver does not stall; the line
// store memory is read on each input transaction and written as the read
// stage advances.
// When the receiver stalls, the output register and read stage hold; in_ready
// drops only once both are full. Reset clears counters, window, valid flags
// and config registers to their defaults; the line store memory is not
// cleared and needs no clearing pass. The user makes cfg_ writes, which take
// effect at once, only while the unit is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamp_unit #(
  parameter int MAX_WIDTH      = rcc_pkg::MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [rcc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rcc_pkg::PIX_W-1:0] in_pix_blue,
  input  logic [rcc_pkg::PIX_W-1:0] in_pix_green,
  input  logic [rcc_pkg::PIX_W-1:0] in_pix_red,
  input  logic                      in_frame_start,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rcc_pkg::PIX_W-1:0] out_blue,
  output logic [rcc_pkg::PIX_W-1:0] out_green,
  output logic [rcc_pkg::PIX_W-1:0] out_red,
  output logic                      out_row_last
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW    = (CW + 1 > rcc_pkg::LWIDTH_W) ? CW + 1 : rcc_pkg::LWIDTH_W;
  localparam int RGB_W = rcc_pkg::RGB_W;
  localparam int PW    = rcc_pkg::PIX_W;
  localparam int MW    = 2 * RGB_W;

  // configuration
  logic [rcc_pkg::LWIDTH_W-1:0] line_width_r;
  logic [rcc_pkg::CFG_W-1:0]    coef_top_r, coef_mid_r, coef_bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= rcc_pkg::LINE_WIDTH_RST;
      coef_top_r   <= rcc_pkg::COEF_TOP_RST;
      coef_mid_r   <= rcc_pkg::COEF_MID_RST;
      coef_bot_r   <= rcc_pkg::COEF_BOT_RST;
    end else if (cfg_wr_en) begin
      case (rcc_pkg::cfg_reg_t'(cfg_index))
        rcc_pkg::REG_LINE_WIDTH: line_width_r <= cfg_data[rcc_pkg::LWIDTH_W-1:0];
        rcc_pkg::REG_COEF_TOP:   coef_top_r   <= cfg_data;
        rcc_pkg::REG_COEF_MID:   coef_mid_r   <= cfg_data;
        rcc_pkg::REG_COEF_BOT:   coef_bot_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc, s1_valid_r, s1_adv, out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // position counters
  logic [CW-1:0] col_cnt_r, col;
  logic [1:0]    row_cnt_r, row;
  logic [EW-1:0] w_raw, w_eff;
  logic          last, emit;

  assign col   = in_frame_start ? '0 : col_cnt_r;
  assign row   = in_frame_start ? '0 : row_cnt_r;
  assign w_raw = EW'(line_width_r);

  always_comb begin
    if (w_raw < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  assign last = EW'(col) >= (w_eff - EW'(1));
  assign emit = (row == 2'd2) && (col >= CW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= last ? '0 : col + CW'(1);
      row_cnt_r <= (last && row != 2'd2) ? row + 2'd1 : row;
    end
  end

  // read stage
  logic [RGB_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_emit_r, s1_last_r;
  logic             byp_hit_r;
  logic [MW-1:0]    byp_r;
  logic [MW-1:0]    rd_r;
  logic [MW-1:0]    rd_eff;
  logic [RGB_W-1:0] rd_a, rd_b;
  logic [MW-1:0]    mem [MAX_WIDTH];

  assign rd_eff = byp_hit_r ? byp_r : rd_r;
  assign rd_a   = rd_eff[MW-1:RGB_W];
  assign rd_b   = rd_eff[RGB_W-1:0];

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_col_r] <= {s1_pix_r, rd_a};
    end
    if (in_acc) begin
      rd_r <= mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (in_acc) begin
      byp_hit_r <= s1_adv && (col == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= {in_pix_red, in_pix_green, in_pix_blue};
      s1_col_r  <= col;
      s1_emit_r <= emit;
      s1_last_r <= last;
      byp_r     <= {s1_pix_r, rd_a};
    end
  end

  // window and filter
  logic [RGB_W-1:0] win_r [3][2];
  logic [RGB_W-1:0] cur [3];
  rcc_pkg::kernel_t kernel;
  rcc_pkg::taps_t   taps [3];
  logic [PW-1:0]    res [3];
  logic [rcc_pkg::CFG_W-1:0] coef_rows [3];

  assign cur[0] = rd_b;
  assign cur[1] = rd_a;
  assign cur[2] = s1_pix_r;

  assign coef_rows[0] = coef_top_r;
  assign coef_rows[1] = coef_mid_r;
  assign coef_rows[2] = coef_bot_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        kernel[3*r+k] = coef_rows[r][rcc_pkg::CFG_W-1-rcc_pkg::COEF_W*k -: rcc_pkg::COEF_W];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        taps[ch][3*r]   = win_r[r][0][PW*ch +: PW];
        taps[ch][3*r+1] = win_r[r][1][PW*ch +: PW];
        taps[ch][3*r+2] = cur[r][PW*ch +: PW];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_ch
    rcc_channel #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_channel (
      .taps  (taps[g]),
      .kernel(kernel),
      .result(res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= '0;
        win_r[r][1] <= '0;
      end
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= cur[r];
      end
    end
  end

  // output register
  logic [PW-1:0] out_blue_r, out_green_r, out_red_r;
  logic          out_row_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_blue_r     <= res[0];
      out_green_r    <= res[1];
      out_red_r      <= res[2];
      out_row_last_r <= s1_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_blue     = out_blue_r;
  assign out_green    = out_green_r;
  assign out_red      = out_red_r;
  assign out_row_last = out_row_last_r;

  // checks
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_col_r) && $stable(rd_eff))
    else $error("read stage changed while stalled");

  a_byp_col0: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && byp_hit_r |-> s1_col_r == '0)
    else $error("line store bypass away from column zero");

  a_row_sat: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r != 2'd3)
    else $error("row counter past saturation");

  a_emit_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit |=> s1_valid_r && s1_emit_r && s1_col_r >= CW'(2))
    else $error("interior result flagged at a border column");

endmodule
